// ===== hw/rtl/dcwm_pkg.sv =====
// shared types and constants for the dark channel window minimum block
// no dependencies; used by dark_channel_window_min and dcwm_min_tree

package dcwm_pkg;

  // payload widths
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 11;
  localparam int CENTER_W   = 11;
  localparam int CFG_W      = 12;
  localparam int RADIUS_W   = 3;
  localparam int MAX_HEIGHT = 2048;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_FRAME_WIDTH   = 2'd0;
  localparam reg_index_t REG_FRAME_HEIGHT  = 2'd1;
  localparam reg_index_t REG_WINDOW_RADIUS = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0]    FRAME_WIDTH_RESET   = 12'd640;
  localparam logic [CFG_W-1:0]    FRAME_HEIGHT_RESET  = 12'd480;
  localparam logic [RADIUS_W-1:0] WINDOW_RADIUS_RESET = 3'd7;

  // per-item result information carried down the pipeline
  typedef struct packed {
    logic                emit;
    logic [CENTER_W-1:0] center_row;
    logic [CENTER_W-1:0] center_col;
    logic                frame_end;
  } result_meta_t;

endpackage

// ===== hw/rtl/dark_channel_window_min.sv =====
// Dark channel filter: a pixel stream in raster order comes in, and for every
// interior pixel the minimum of all three channels over a (2*radius+1) square
// window comes out when the window's bottom-right pixel arrives. The block
// sustains one item per clock unless dark_ready stalls it; items pass stages
// one and two to the output register. The rate is set by the line memory,
// which holds every buffered line of one column in a single word and is read,
// updated and written back once per pixel; back-to-back pixels in the same
// column (one-pixel-wide frames) are covered by forwarding. Line memory
// contents are undefined after reset, so the block needs no clearing pass and
// accepts items straight away; only a frame whose windows reach rows not yet
// written gives undefined values. Reconfigure only while no item is in flight.
// depends on dcwm_pkg, dcwm_line_buf and dcwm_min_tree

module dark_channel_window_min #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel items
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [dcwm_pkg::PIX_W-1:0]        blue,
  input  logic [dcwm_pkg::PIX_W-1:0]        green,
  input  logic [dcwm_pkg::PIX_W-1:0]        red,
  // result items
  output logic                              dark_valid,
  input  logic                              dark_ready,
  output logic [dcwm_pkg::PIX_W-1:0]        dark,
  output logic [dcwm_pkg::CENTER_W-1:0]     center_row,
  output logic [dcwm_pkg::CENTER_W-1:0]     center_col,
  output logic                              frame_end,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dcwm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dcwm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dcwm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int PW     = dcwm_pkg::PIX_W;
  localparam int LC     = 2 * MAX_RADIUS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SW     = $clog2(LC);
  localparam int XW     = (CW + 1 > dcwm_pkg::CFG_W) ? CW + 1 : dcwm_pkg::CFG_W;
  localparam int RW     = dcwm_pkg::ROW_W;
  localparam int HW     = dcwm_pkg::CFG_W;
  localparam int WORD_W = LC * PW;

  // configuration registers
  logic [dcwm_pkg::CFG_W-1:0]    frame_width;
  logic [dcwm_pkg::CFG_W-1:0]    frame_height;
  logic [dcwm_pkg::RADIUS_W-1:0] window_radius;
  logic                          cfg_write;
  dcwm_pkg::reg_index_t          cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= dcwm_pkg::FRAME_WIDTH_RESET;
      frame_height  <= dcwm_pkg::FRAME_HEIGHT_RESET;
      window_radius <= dcwm_pkg::WINDOW_RADIUS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dcwm_pkg::REG_FRAME_WIDTH:   frame_width   <= pwdata[dcwm_pkg::CFG_W-1:0];
        dcwm_pkg::REG_FRAME_HEIGHT:  frame_height  <= pwdata[dcwm_pkg::CFG_W-1:0];
        dcwm_pkg::REG_WINDOW_RADIUS: window_radius <= pwdata[dcwm_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_index)
      dcwm_pkg::REG_FRAME_WIDTH:   prdata = dcwm_pkg::APB_DATA_W'(frame_width);
      dcwm_pkg::REG_FRAME_HEIGHT:  prdata = dcwm_pkg::APB_DATA_W'(frame_height);
      dcwm_pkg::REG_WINDOW_RADIUS: prdata = dcwm_pkg::APB_DATA_W'(window_radius);
      default:                     prdata = '0;
    endcase
  end

  // effective frame size and radius, saturated to the supported range
  logic [XW-1:0] width_x;
  logic [XW-1:0] frame_width_x;
  logic [HW-1:0] height_x;
  logic [4:0]    radius_x;
  logic [5:0]    side;

  assign frame_width_x = XW'(frame_width);

  always_comb begin
    if (frame_width == '0) begin
      width_x = XW'(1);
    end else if (frame_width_x > XW'(MAX_WIDTH)) begin
      width_x = XW'(MAX_WIDTH);
    end else begin
      width_x = frame_width_x;
    end
    if (frame_height == '0) begin
      height_x = HW'(1);
    end else if (frame_height > HW'(dcwm_pkg::MAX_HEIGHT)) begin
      height_x = HW'(dcwm_pkg::MAX_HEIGHT);
    end else begin
      height_x = frame_height;
    end
    if (5'(window_radius) > 5'(MAX_RADIUS)) begin
      radius_x = 5'(MAX_RADIUS);
    end else begin
      radius_x = 5'(window_radius);
    end
  end

  assign side = {radius_x, 1'b0};

  // position of the next pixel (wrapped lazily, as after a reconfiguration)
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [SW-1:0] row_slot;

  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [SW-1:0] slot_cur;
  logic          col_wrap;
  logic [RW:0]   row_inc;
  logic [SW-1:0] slot_inc;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic [SW-1:0] row_slot_next;
  logic [CW:0]   col_plus;
  logic [RW:0]   row_plus;

  always_comb begin
    col_wrap = XW'(col_count) >= width_x;
    col_cur  = col_wrap ? '0 : col_count;
    row_inc  = col_wrap ? {1'b0, row_count} + 1'b1 : {1'b0, row_count};
    if (col_wrap) begin
      slot_inc = (row_slot == SW'(LC - 1)) ? '0 : row_slot + 1'b1;
    end else begin
      slot_inc = row_slot;
    end
    if (HW'(row_inc) >= height_x) begin
      row_cur  = '0;
      slot_cur = '0;
    end else begin
      row_cur  = row_inc[RW-1:0];
      slot_cur = slot_inc;
    end

    // advance past the pixel being taken
    col_plus = {1'b0, col_cur} + 1'b1;
    row_plus = {1'b0, row_cur} + 1'b1;
    if (XW'(col_plus) >= width_x) begin
      col_count_next = '0;
      if (HW'(row_plus) >= height_x) begin
        row_count_next = '0;
        row_slot_next  = '0;
      end else begin
        row_count_next = row_plus[RW-1:0];
        row_slot_next  = (slot_cur == SW'(LC - 1)) ? '0 : slot_cur + 1'b1;
      end
    end else begin
      col_count_next = col_plus[CW-1:0];
      row_count_next = row_cur;
      row_slot_next  = slot_cur;
    end
  end

  // pipeline handshake
  logic s1_valid;
  logic s2_valid;
  logic adv1;
  logic adv2;
  logic accept;
  dcwm_pkg::result_meta_t s1_meta;
  dcwm_pkg::result_meta_t s2_meta;

  assign adv2        = s2_valid && (!s2_meta.emit || !dark_valid || dark_ready);
  assign adv1        = s1_valid && (!s2_valid || adv2);
  assign pixel_ready = !s1_valid || adv1;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      row_slot  <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      row_slot  <= row_slot_next;
    end
  end

  // per-item information worked out at acceptance
  logic [PW-1:0]  pix_min;
  logic [LC-1:0]  line_mask;
  logic           row_inside;
  logic [SW:0]    slot_gap;
  logic [XW-1:0]  col_cur_x;
  logic [XW-1:0]  center_col_x;
  dcwm_pkg::result_meta_t meta_cur;

  always_comb begin
    pix_min    = (blue < green) ? blue : green;
    pix_min    = (red < pix_min) ? red : pix_min;
    row_inside = row_cur >= RW'(side);
    // lines holding rows row-1 .. row-side; with the widest window the line
    // about to be overwritten still holds the oldest row of the window
    for (int s = 0; s < LC; s++) begin
      if (slot_cur >= SW'(s)) begin
        slot_gap = {1'b0, slot_cur} - (SW + 1)'(s);
      end else begin
        slot_gap = {1'b0, slot_cur} + (SW + 1)'(LC - s);
      end
      line_mask[s] = row_inside &&
                     ((slot_gap != '0) ? (6'(slot_gap) <= side) : (side == 6'(LC)));
    end
    col_cur_x           = XW'(col_cur);
    center_col_x        = col_cur_x - XW'(radius_x);
    meta_cur.emit       = row_inside && (col_cur_x >= XW'(side));
    meta_cur.center_row = row_cur - RW'(radius_x);
    meta_cur.center_col = center_col_x[dcwm_pkg::CENTER_W-1:0];
    meta_cur.frame_end  = (HW'(row_cur) == height_x - 1'b1) &&
                          (col_cur_x == width_x - 1'b1);
  end

  // stage one: line word arrives from memory
  logic [PW-1:0]   s1_pix;
  logic [CW-1:0]   s1_col;
  logic [SW-1:0]   s1_slot;
  logic [LC-1:0]   s1_mask;
  logic            s1_fwd_hit;
  logic [SW-1:0]   s1_fwd_slot;
  logic [PW-1:0]   s1_fwd_pix;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] merged_word;
  logic [WORD_W-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
  end

  // the item leaving stage one writes its column at the edge that reads ours
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pix_min;
      s1_col      <= col_cur;
      s1_slot     <= slot_cur;
      s1_mask     <= line_mask;
      s1_meta     <= meta_cur;
      s1_fwd_hit  <= adv1 && (s1_col == col_cur);
      s1_fwd_slot <= s1_slot;
      s1_fwd_pix  <= s1_pix;
    end
  end

  dcwm_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (WORD_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (rd_word),
    .wr_en   (adv1),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  // forward the missed write, then insert this pixel into its line
  logic [(LC+1)*PW-1:0] vert_vals;
  logic [PW-1:0]        vert_min;

  always_comb begin
    merged_word = rd_word;
    if (s1_fwd_hit) begin
      merged_word[s1_fwd_slot*PW +: PW] = s1_fwd_pix;
    end
    wr_word = merged_word;
    wr_word[s1_slot*PW +: PW] = s1_pix;
    vert_vals[PW-1:0] = s1_pix;
    for (int s = 0; s < LC; s++) begin
      vert_vals[(s+1)*PW +: PW] = s1_mask[s] ? merged_word[s*PW +: PW] : '1;
    end
  end

  dcwm_min_tree #(
    .N (LC + 1)
  ) u_vert_min (
    .vals    (vert_vals),
    .min_val (vert_min)
  );

  // stage two: row of column minima, newest in tap zero
  logic [PW-1:0] col_min [LC+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv1) begin
      s2_valid <= 1'b1;
    end else if (adv2) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      col_min[0] <= vert_min;
      for (int k = 1; k <= LC; k++) begin
        col_min[k] <= col_min[k-1];
      end
      s2_meta <= s1_meta;
    end
  end

  // horizontal minimum over the current and the previous side columns
  logic [(LC+1)*PW-1:0] horiz_vals;
  logic [PW-1:0]        horiz_min;

  always_comb begin
    for (int k = 0; k <= LC; k++) begin
      horiz_vals[k*PW +: PW] = (6'(k) <= side) ? col_min[k] : '1;
    end
  end

  dcwm_min_tree #(
    .N (LC + 1)
  ) u_horiz_min (
    .vals    (horiz_vals),
    .min_val (horiz_min)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dark_valid <= 1'b0;
    end else if (adv2 && s2_meta.emit) begin
      dark_valid <= 1'b1;
    end else if (dark_ready) begin
      dark_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_meta.emit) begin
      dark       <= horiz_min;
      center_row <= s2_meta.center_row;
      center_col <= s2_meta.center_col;
      frame_end  <= s2_meta.frame_end;
    end
  end

endmodule

// ===== hw/rtl/dcwm_line_buf.sv =====
// line buffer memory: one word per column holding every buffered line
// depends on nothing; instantiated by dark_channel_window_min

module dcwm_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int WORD_W = 112
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/dcwm_min_tree.sv =====
// balanced minimum tree over N byte-wide values
// uses dcwm_pkg for the value width

module dcwm_min_tree #(
  parameter int N = 15
) (
  input  logic [N*dcwm_pkg::PIX_W-1:0] vals,
  output logic [dcwm_pkg::PIX_W-1:0]   min_val
);

  localparam int P = 1 << $clog2(N);

  logic [dcwm_pkg::PIX_W-1:0] node [2*P-1];

  // leaves padded with all ones, then pairwise reduction towards the root
  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < N) begin
        node[P-1+i] = vals[i*dcwm_pkg::PIX_W +: dcwm_pkg::PIX_W];
      end else begin
        node[P-1+i] = '1;
      end
    end
    for (int i = P - 2; i >= 0; i--) begin
      node[i] = (node[2*i+1] < node[2*i+2]) ? node[2*i+1] : node[2*i+2];
    end
  end

  assign min_val = node[0];

endmodule
